// ===== hdl/sfdc_pkg.sv =====
// ----------------------------------------------------------------------------
// sfdc_pkg
// shared types and constants of the sphere frustum distance cull block
// ----------------------------------------------------------------------------
package sfdc_pkg;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 64;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_LEFT   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_RIGHT  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_BOTTOM = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_TOP    = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_NEAR   = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_FAR    = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CAMERA       = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE       = 4'd7;

  // number of planes reachable from the register file
  localparam int CFG_PLANES = 6;

  // reset values: zero normal with a large offset never culls
  localparam logic [CFG_DATA_W-1:0] PLANE_RESET    = 64'd32767;
  localparam logic [CFG_DATA_W-1:0] CAMERA_RESET   = 64'd1600;
  localparam logic [31:0]           RANGE_SQ_RESET = 32'd2560000;

  // cull reason codes
  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_DIST    = 2'd1;
  localparam logic [1:0] REASON_FRUSTUM = 2'd2;

  typedef struct packed {
    logic [15:0]        object_tag;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic [14:0]        sphere_radius;
  } sfdc_in_t;

  typedef struct packed {
    logic [15:0] result_tag;
    logic        culled;
    logic [1:0]  cull_reason;
  } sfdc_out_t;

  // per-object data that rides along the pipeline
  typedef struct packed {
    logic [15:0] tag;
    logic [14:0] radius;
    logic        far;
    logic        hit;
  } sfdc_side_t;

endpackage

// ===== hdl/sfdc_dist.sv =====
// ----------------------------------------------------------------------------
// sfdc_dist
// three-stage squared distance test against the camera and cull range
// ----------------------------------------------------------------------------
module sfdc_dist #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [2:0][15:0]                cam,
  input  logic [31:0]                     range_sq,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  sfdc_pkg::sfdc_side_t            up_side,
  input  logic [2:0][COORD_WIDTH-1:0]     up_center,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output sfdc_pkg::sfdc_side_t            dn_side,
  output logic [2:0][COORD_WIDTH-1:0]     dn_center
);
  import sfdc_pkg::*;

  localparam int DW = ((COORD_WIDTH > 16) ? COORD_WIDTH : 16) + 1;

  logic                        s1_vld_r, s2_vld_r, s3_vld_r;
  logic                        s1_rdy, s2_rdy, s3_rdy;
  logic [2:0][15:0]            s1_mag_r;
  logic                        s1_big_r, s2_big_r;
  logic [2:0][31:0]            s2_sq_r;
  sfdc_side_t                  s1_side_r, s2_side_r, s3_side_r;
  logic [2:0][COORD_WIDTH-1:0] s1_center_r, s2_center_r, s3_center_r;

  logic signed [DW-1:0] diff [3];
  logic [2:0][DW-1:0]   mag;
  logic                 big_nxt;
  logic [33:0]          dist_sq;
  sfdc_side_t           side3_nxt;

  assign s3_rdy   = !s3_vld_r || dn_ready;
  assign s2_rdy   = !s2_vld_r || s3_rdy;
  assign s1_rdy   = !s1_vld_r || s2_rdy;
  assign up_ready = s1_rdy;

  // difference and magnitude; a component of 2^16 or more is already too far
  always_comb begin
    big_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      diff[k] = DW'(signed'(up_center[k])) - DW'(signed'(cam[k]));
      mag[k]  = diff[k][DW-1] ? DW'(-diff[k]) : DW'(diff[k]);
      big_nxt = big_nxt | (mag[k][DW-1:16] != '0);
    end
  end

  assign dist_sq = 34'(s2_sq_r[0]) + 34'(s2_sq_r[1]) + 34'(s2_sq_r[2]);

  always_comb begin
    side3_nxt     = s2_side_r;
    side3_nxt.far = s2_big_r || (dist_sq > 34'(range_sq));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= up_valid;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
      if (s3_rdy) s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && up_valid) begin
      for (int k = 0; k < 3; k++) s1_mag_r[k] <= mag[k][15:0];
      s1_big_r    <= big_nxt;
      s1_side_r   <= up_side;
      s1_center_r <= up_center;
    end
    if (s2_rdy && s1_vld_r) begin
      for (int k = 0; k < 3; k++) s2_sq_r[k] <= s1_mag_r[k] * s1_mag_r[k];
      s2_big_r    <= s1_big_r;
      s2_side_r   <= s1_side_r;
      s2_center_r <= s1_center_r;
    end
    if (s3_rdy && s2_vld_r) begin
      s3_side_r   <= side3_nxt;
      s3_center_r <= s2_center_r;
    end
  end

  assign dn_valid  = s3_vld_r;
  assign dn_side   = s3_side_r;
  assign dn_center = s3_center_r;

endmodule

// ===== hdl/sfdc_plane_cell.sv =====
// ----------------------------------------------------------------------------
// sfdc_plane_cell
// one frustum plane: registered products, then sum and sign test
// ----------------------------------------------------------------------------
module sfdc_plane_cell #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [63:0]                     plane,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  sfdc_pkg::sfdc_side_t            up_side,
  input  logic [2:0][COORD_WIDTH-1:0]     up_center,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output sfdc_pkg::sfdc_side_t            dn_side,
  output logic [2:0][COORD_WIDTH-1:0]     dn_center
);
  import sfdc_pkg::*;

  localparam int PW = COORD_WIDTH + 16;
  localparam int SW = ((PW > 31) ? PW : 31) + 3;

  logic signed [15:0] nrm [3];
  logic signed [15:0] ofs;
  logic signed [16:0] rad_s;
  logic signed [PW-1:0] prod_nxt [3];

  logic                        a_vld_r, b_vld_r;
  logic                        a_rdy, b_rdy;
  logic signed [PW-1:0]        a_prod_r [3];
  logic signed [16:0]          a_base_r;
  sfdc_side_t                  a_side_r, b_side_r;
  logic [2:0][COORD_WIDTH-1:0] a_center_r, b_center_r;

  logic signed [SW-1:0] sum;
  sfdc_side_t           side_b_nxt;

  assign nrm[0] = signed'(plane[63:48]);
  assign nrm[1] = signed'(plane[47:32]);
  assign nrm[2] = signed'(plane[31:16]);
  assign ofs    = signed'(plane[15:0]);
  assign rad_s  = signed'({2'b00, up_side.radius});

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_nxt[k] = PW'(nrm[k]) * PW'(signed'(up_center[k]));
    end
  end

  assign b_rdy    = !b_vld_r || dn_ready;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign up_ready = a_rdy;

  // n.c + (d + r) * 2^14 below zero means fully outside this plane
  assign sum = SW'(a_prod_r[0]) + SW'(a_prod_r[1]) + SW'(a_prod_r[2])
             + (SW'(a_base_r) <<< 14);

  always_comb begin
    side_b_nxt     = a_side_r;
    side_b_nxt.hit = a_side_r.hit | sum[SW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_rdy) a_vld_r <= up_valid;
      if (b_rdy) b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && up_valid) begin
      for (int k = 0; k < 3; k++) a_prod_r[k] <= prod_nxt[k];
      a_base_r   <= 17'(ofs) + rad_s;
      a_side_r   <= up_side;
      a_center_r <= up_center;
    end
    if (b_rdy && a_vld_r) begin
      b_side_r   <= side_b_nxt;
      b_center_r <= a_center_r;
    end
  end

  assign dn_valid  = b_vld_r;
  assign dn_side   = b_side_r;
  assign dn_center = b_center_r;

endmodule

// ===== hdl/sphere_frustum_distance_cull.sv =====
// ----------------------------------------------------------------------------
// sphere_frustum_distance_cull
// classifies bounding spheres against the camera cull range and frustum planes
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload                 direction
//  in       in_valid / in_ready    in_req  (sfdc_in_t)     sphere requests in
//  out      out_valid / out_ready  out_rsp (sfdc_out_t)    results out
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data     register writes in
//
//  one request per cycle sustained while out_ready stays high; a request passes
//  three distance stages, two stages per plane cell and the output register
//  every stage has its own valid and ready, so bubbles are squeezed out and a
//  request is taken while a result waits at the output
//  in_ready goes low only when every stage is full and out_ready is low
//  rst_n is synchronous; it empties the pipeline and loads the register
//  defaults (never-culling planes, camera at origin, range 1600, frustum on)
//  cfg_ready is always high; writes are expected only with the pipeline empty
//
module sphere_frustum_distance_cull #(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sfdc_pkg::sfdc_in_t                   in_req,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sfdc_pkg::sfdc_out_t                  out_rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sfdc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfdc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sfdc_pkg::*;

  // planes the register file can reach; cells beyond stay at the reset plane
  localparam int StoredPlanes = (PLANE_COUNT < CFG_PLANES) ? PLANE_COUNT : CFG_PLANES;

  // ---------------------------------------------------------------- config
  logic [CFG_DATA_W-1:0] plane_r [StoredPlanes];
  logic [CFG_DATA_W-1:0] camera_r;
  logic [31:0]           range_sq_r;
  logic                  enable_r;
  logic                  cfg_wr;
  logic [2:0][15:0]      cam;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < StoredPlanes; j++) plane_r[j] <= PLANE_RESET;
      camera_r   <= CAMERA_RESET;
      range_sq_r <= RANGE_SQ_RESET;
      enable_r   <= 1'b1;
    end else if (cfg_wr) begin
      for (int j = 0; j < StoredPlanes; j++) begin
        if (cfg_index == CFG_INDEX_W'(j)) plane_r[j] <= cfg_data;
      end
      if (cfg_index == REG_CAMERA) begin
        camera_r   <= cfg_data;
        // squared range kept with the camera so the compare stage has no multiply
        range_sq_r <= cfg_data[15:0] * cfg_data[15:0];
      end
      if (cfg_index == REG_ENABLE) enable_r <= cfg_data[0];
    end
  end

  assign cam[0] = camera_r[63:48];
  assign cam[1] = camera_r[47:32];
  assign cam[2] = camera_r[31:16];

  // ---------------------------------------------------------------- input
  sfdc_side_t                  in_side;
  logic [2:0][COORD_WIDTH-1:0] in_center;

  always_comb begin
    in_side        = '0;
    in_side.tag    = in_req.object_tag;
    in_side.radius = in_req.sphere_radius;
  end

  // coordinates are taken at COORD_WIDTH bits
  if (COORD_WIDTH >= 16) begin : g_widen
    assign in_center[0] = COORD_WIDTH'(in_req.center_x);
    assign in_center[1] = COORD_WIDTH'(in_req.center_y);
    assign in_center[2] = COORD_WIDTH'(in_req.center_z);
  end else begin : g_narrow
    assign in_center[0] = in_req.center_x[COORD_WIDTH-1:0];
    assign in_center[1] = in_req.center_y[COORD_WIDTH-1:0];
    assign in_center[2] = in_req.center_z[COORD_WIDTH-1:0];
  end

  // ---------------------------------------------------------------- pipeline
  logic                        ch_valid  [PLANE_COUNT+1];
  logic                        ch_ready  [PLANE_COUNT+1];
  sfdc_side_t                  ch_side   [PLANE_COUNT+1];
  logic [2:0][COORD_WIDTH-1:0] ch_center [PLANE_COUNT+1];

  sfdc_dist #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .cam       (cam),
    .range_sq  (range_sq_r),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .up_side   (in_side),
    .up_center (in_center),
    .dn_valid  (ch_valid[0]),
    .dn_ready  (ch_ready[0]),
    .dn_side   (ch_side[0]),
    .dn_center (ch_center[0])
  );

  // row of plane cells, each handing the request to its neighbor
  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    logic [CFG_DATA_W-1:0] cell_plane;

    if (g < StoredPlanes) begin : g_cfg
      assign cell_plane = plane_r[g];
    end else begin : g_fixed
      assign cell_plane = PLANE_RESET;
    end

    sfdc_plane_cell #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .plane     (cell_plane),
      .up_valid  (ch_valid[g]),
      .up_ready  (ch_ready[g]),
      .up_side   (ch_side[g]),
      .up_center (ch_center[g]),
      .dn_valid  (ch_valid[g+1]),
      .dn_ready  (ch_ready[g+1]),
      .dn_side   (ch_side[g+1]),
      .dn_center (ch_center[g+1])
    );
  end

  // ---------------------------------------------------------------- output
  logic       out_vld_r;
  sfdc_out_t  out_r;
  sfdc_out_t  out_nxt;
  logic       out_rdy;
  sfdc_side_t last_side;

  assign last_side           = ch_side[PLANE_COUNT];
  assign out_rdy             = !out_vld_r || out_ready;
  assign ch_ready[PLANE_COUNT] = out_rdy;

  // distance wins over frustum; plane hits count only when enabled
  always_comb begin
    out_nxt            = '0;
    out_nxt.result_tag = last_side.tag;
    if (last_side.far) begin
      out_nxt.cull_reason = REASON_DIST;
    end else if (enable_r && last_side.hit) begin
      out_nxt.cull_reason = REASON_FRUSTUM;
    end else begin
      out_nxt.cull_reason = REASON_NONE;
    end
    out_nxt.culled = (out_nxt.cull_reason != REASON_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_rdy) begin
      out_vld_r <= ch_valid[PLANE_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && ch_valid[PLANE_COUNT]) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_rsp   = out_r;

  // ---------------------------------------------------------------- checks
  // back pressure reaches the input only when the output is stalled
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back pressure");

  // a frustum cull never appears while the plane test is switched off
  a_frustum_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !enable_r) |-> (out_rsp.cull_reason != REASON_FRUSTUM))
    else $error("frustum reason with frustum test disabled");

  // the reason code is always a defined one
  a_reason_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.cull_reason == REASON_NONE
                || out_rsp.cull_reason == REASON_DIST
                || out_rsp.cull_reason == REASON_FRUSTUM))
    else $error("undefined cull reason");

  // a result appears only after requests have entered the pipeline
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(ch_valid[PLANE_COUNT]))
    else $error("result without a request in the last stage");

endmodule
